// File: src/qvr_pkg.sv
// Package for the quaternion vector rotation pipeline.
// Holds the payload structs and the internal arithmetic widths. No dependencies.
package qvr_pkg;

  localparam int unsigned VecW  = 16;              // vector and quaternion field width
  localparam int unsigned UW    = VecW + 1;        // vector part after optional negation
  localparam int unsigned UvW   = UW + VecW;       // u_i * v_j
  localparam int unsigned UuW   = 2 * UW;          // u_i * u_i
  localparam int unsigned SsW   = 2 * VecW;        // s * s
  localparam int unsigned DuvW  = UvW + 2;         // sum of three u_i * v_i
  localparam int unsigned DuuW  = UuW + 2;         // sum of three u_i * u_i
  localparam int unsigned KW    = DuuW + 1;        // s*s - u.u
  localparam int unsigned CrsW  = UvW + 1;         // one cross product component
  localparam int unsigned AW    = DuvW + UW;       // (u.v) * u_i
  localparam int unsigned BW    = KW + VecW;       // k * v_i
  localparam int unsigned EW    = VecW + CrsW;     // s * c_i
  localparam int unsigned RW    = BW + 3;          // sum of the three terms
  localparam int unsigned OutShift = 28;           // Q2.14 squared back to integer units
  localparam int unsigned RndW  = RW - OutShift;   // rounded component before saturation

  typedef struct packed {
    logic signed [VecW-1:0] vec_x;
    logic signed [VecW-1:0] vec_y;
    logic signed [VecW-1:0] vec_z;
    logic signed [VecW-1:0] quat_w;
    logic signed [VecW-1:0] quat_x;
    logic signed [VecW-1:0] quat_y;
    logic signed [VecW-1:0] quat_z;
    logic                   inverse;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VecW-1:0] rot_x;
    logic signed [VecW-1:0] rot_y;
    logic signed [VecW-1:0] rot_z;
    logic                   clipped;
  } qvr_out_t;

endpackage

// File: src/qvr_round_sat.sv
// Rounds one rotated component from scale 2^28 to integer units and saturates it.
// Depends on qvr_pkg for widths.
module qvr_round_sat import qvr_pkg::*; (
  input  logic signed [RW-1:0]   sum_i,   // already carries the half-unit bias
  output logic signed [VecW-1:0] rot_o,
  output logic                   clip_o
);

  localparam logic signed [RndW-1:0] MaxVal = RndW'((1 << (VecW - 1)) - 1);
  localparam logic signed [RndW-1:0] MinVal = -RndW'(1 << (VecW - 1));

  logic signed [RW-1:0]   shifted;
  logic signed [RndW-1:0] rnd;

  always_comb begin
    // An arithmetic shift of the biased sum is floor division, i.e. round half up.
    shifted = sum_i >>> OutShift;
    rnd     = shifted[RndW-1:0];
    clip_o  = 1'b0;
    if (rnd > MaxVal) begin
      rot_o  = MaxVal[VecW-1:0];
      clip_o = 1'b1;
    end else if (rnd < MinVal) begin
      rot_o  = MinVal[VecW-1:0];
      clip_o = 1'b1;
    end else begin
      rot_o  = rnd[VecW-1:0];
    end
  end

endmodule

// File: src/quaternion_vector_rotate.sv
// Rotates a 16-bit integer vector by a Q2.14 quaternion, r = 2(u.v)u + (s*s-u.u)v + 2s(u x v),
// and rounds and saturates the result to 16 bits. One word is accepted per clock when the
// output side keeps taking words; there are six register stages: input
// negation, the nine cross and dot products with the squares, the dot and cross sums, the
// three wide products per component, the final three-term sum, and rounding with saturation.
// The quaternion is not normalized, so a quaternion of norm m scales the vector by m*m.
// Stalls hold each stage in place; a stage with no word in it keeps accepting.
// Depends on qvr_pkg and qvr_round_sat.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qvr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qvr_out_t out_data_o
);

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;

  // Stage 1: operands, vector part negated for the inverse rotation.
  logic signed [UW-1:0]   u1_q [3];
  logic signed [VecW-1:0] v1_q [3];
  logic signed [VecW-1:0] s1_q;
  // Stage 2: products.
  logic signed [UvW-1:0]  dp2_q [3];
  logic signed [UvW-1:0]  cp2_q [3];
  logic signed [UvW-1:0]  cn2_q [3];
  logic signed [UuW-1:0]  uu2_q [3];
  logic signed [SsW-1:0]  ss2_q;
  logic signed [UW-1:0]   u2_q [3];
  logic signed [VecW-1:0] v2_q [3];
  logic signed [VecW-1:0] s2_q;
  // Stage 3: sums.
  logic signed [DuvW-1:0] duv3_q;
  logic signed [KW-1:0]   k3_q;
  logic signed [CrsW-1:0] c3_q [3];
  logic signed [UW-1:0]   u3_q [3];
  logic signed [VecW-1:0] v3_q [3];
  logic signed [VecW-1:0] s3_q;
  // Stage 4: wide products.
  logic signed [AW-1:0]   a4_q [3];
  logic signed [BW-1:0]   b4_q [3];
  logic signed [EW-1:0]   e4_q [3];
  // Stage 5: biased sum; stage 6: output word.
  logic signed [RW-1:0]   r5_q [3];
  qvr_out_t               out_q;

  logic signed [UW-1:0]   u_neg [3];
  logic signed [DuuW-1:0] duu;
  logic signed [VecW-1:0] rot [3];
  logic [2:0]             clip;

  // Each stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    u_neg[0] = UW'(in_data_i.quat_x);
    u_neg[1] = UW'(in_data_i.quat_y);
    u_neg[2] = UW'(in_data_i.quat_z);
    if (in_data_i.inverse) begin
      for (int i = 0; i < 3; i++) begin
        u_neg[i] = -u_neg[i];
      end
    end
  end

  assign duu = DuuW'(uu2_q[0]) + DuuW'(uu2_q[1]) + DuuW'(uu2_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      u1_q    <= u_neg;
      v1_q[0] <= in_data_i.vec_x;
      v1_q[1] <= in_data_i.vec_y;
      v1_q[2] <= in_data_i.vec_z;
      s1_q    <= in_data_i.quat_w;
    end
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        dp2_q[i] <= u1_q[i] * v1_q[i];
        uu2_q[i] <= u1_q[i] * u1_q[i];
      end
      // Cross product terms: positive and negative halves of each component.
      cp2_q[0] <= u1_q[1] * v1_q[2];
      cn2_q[0] <= u1_q[2] * v1_q[1];
      cp2_q[1] <= u1_q[2] * v1_q[0];
      cn2_q[1] <= u1_q[0] * v1_q[2];
      cp2_q[2] <= u1_q[0] * v1_q[1];
      cn2_q[2] <= u1_q[1] * v1_q[0];
      ss2_q    <= s1_q * s1_q;
      u2_q     <= u1_q;
      v2_q     <= v1_q;
      s2_q     <= s1_q;
    end
    if (rdy[2]) begin
      duv3_q <= DuvW'(dp2_q[0]) + DuvW'(dp2_q[1]) + DuvW'(dp2_q[2]);
      k3_q   <= KW'(ss2_q) - KW'(duu);
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= CrsW'(cp2_q[i]) - CrsW'(cn2_q[i]);
      end
      u3_q <= u2_q;
      v3_q <= v2_q;
      s3_q <= s2_q;
    end
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        a4_q[i] <= duv3_q * u3_q[i];
        b4_q[i] <= k3_q * v3_q[i];
        e4_q[i] <= s3_q * c3_q[i];
      end
    end
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        r5_q[i] <= (RW'(a4_q[i]) <<< 1) + RW'(b4_q[i]) + (RW'(e4_q[i]) <<< 1)
                 + RW'(1 << (OutShift - 1));
      end
    end
    if (rdy[5]) begin
      out_q.rot_x   <= rot[0];
      out_q.rot_y   <= rot[1];
      out_q.rot_z   <= rot[2];
      out_q.clipped <= |clip;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_round
    qvr_round_sat u_round_sat (
      .sum_i  (r5_q[g]),
      .rot_o  (rot[g]),
      .clip_o (clip[g])
    );
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench for quaternion_vector_rotate: directed and random words checked against
// a rotation predictor in this file. Depends on qvr_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import qvr_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  qvr_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  qvr_out_t out_data_o;

  qvr_out_t rotations_due[$];
  int       mismatch_count = 0;
  bit       gaps_on = 1'b0;
  bit       stalls_on = 1'b0;

  quaternion_vector_rotate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Exact rotation at scale 2^28, then round half up and saturate each component.
  function automatic qvr_out_t rotate_vector(input qvr_in_t w);
    longint   v [3];
    longint   u [3];
    longint   cr [3];
    longint   s, uv, uu, k, acc, rnd;
    logic [VecW-1:0] comp [3];
    bit       clip;
    qvr_out_t r;
    clip = 1'b0;
    v[0] = longint'($signed(w.vec_x));
    v[1] = longint'($signed(w.vec_y));
    v[2] = longint'($signed(w.vec_z));
    s    = longint'($signed(w.quat_w));
    u[0] = longint'($signed(w.quat_x));
    u[1] = longint'($signed(w.quat_y));
    u[2] = longint'($signed(w.quat_z));
    if (w.inverse) begin
      for (int i = 0; i < 3; i++) u[i] = -u[i];
    end
    uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    k  = s * s - uu;
    cr[0] = u[1] * v[2] - v[1] * u[2];
    cr[1] = v[0] * u[2] - u[0] * v[2];
    cr[2] = u[0] * v[1] - v[0] * u[1];
    for (int i = 0; i < 3; i++) begin
      acc = 2 * uv * u[i] + k * v[i] + 2 * s * cr[i];
      // An arithmetic shift of a signed value is a floor division.
      rnd = (acc + 64'sd134217728) >>> OutShift;
      if (rnd > 32767) begin
        rnd = 32767;
        clip = 1'b1;
      end else if (rnd < -32768) begin
        rnd = -32768;
        clip = 1'b1;
      end
      comp[i] = rnd[VecW-1:0];
    end
    r.rot_x   = comp[0];
    r.rot_y   = comp[1];
    r.rot_z   = comp[2];
    r.clipped = clip;
    return r;
  endfunction

  function automatic qvr_in_t make_word(input int vx, input int vy, input int vz,
                                        input int qw, input int qx, input int qy,
                                        input int qz, input bit inv);
    qvr_in_t w;
    w.vec_x   = 16'(vx);
    w.vec_y   = 16'(vy);
    w.vec_z   = 16'(vz);
    w.quat_w  = 16'(qw);
    w.quat_x  = 16'(qx);
    w.quat_y  = 16'(qy);
    w.quat_z  = 16'(qz);
    w.inverse = inv;
    return w;
  endfunction

  // Mostly near-unit quaternions on random vectors, some small random quaternions, the rest raw bit patterns.
  function automatic qvr_in_t random_word();
    qvr_in_t      w;
    logic [127:0] raw;
    real          a, b, c, d, n, g;
    int           pick, vr;
    pick = $urandom_range(0, 9);
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(qvr_in_t)-1:0];
    if (pick < 6) begin
      a = real'(int'($urandom_range(0, 32768)) - 16384);
      b = real'(int'($urandom_range(0, 32768)) - 16384);
      c = real'(int'($urandom_range(0, 32768)) - 16384);
      d = real'(int'($urandom_range(0, 32768)) - 16384);
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 16384.0;
        n = 16384.0;
      end
      // Gain of 0.5 to 2.0 on some words so the norm is not always exact.
      g = (pick == 5) ? (0.5 + real'($urandom_range(0, 1500)) / 1000.0) : 1.0;
      g = g * 16384.0 / n;
      w.quat_w = 16'($rtoi(a * g));
      w.quat_x = 16'($rtoi(b * g));
      w.quat_y = 16'($rtoi(c * g));
      w.quat_z = 16'($rtoi(d * g));
      if ($urandom_range(0, 1) == 0) begin
        vr = $urandom_range(1, 2000);
        w.vec_x = 16'(int'($urandom_range(0, 2 * vr)) - vr);
        w.vec_y = 16'(int'($urandom_range(0, 2 * vr)) - vr);
        w.vec_z = 16'(int'($urandom_range(0, 2 * vr)) - vr);
      end
    end else if (pick < 8) begin
      w.quat_w = 16'(int'($urandom_range(0, 8192)) - 4096);
      w.quat_x = 16'(int'($urandom_range(0, 8192)) - 4096);
      w.quat_y = 16'(int'($urandom_range(0, 8192)) - 4096);
      w.quat_z = 16'(int'($urandom_range(0, 8192)) - 4096);
    end
    return w;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // Entered just after a rising edge; returns at the edge that takes the word.
  task automatic send_word(input qvr_in_t w);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    rotations_due.push_back(rotate_vector(w));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (rotations_due.size() != 0) @(posedge clk_i);
  endtask

  // Output side: random stall bursts while enabled, otherwise always ready.
  initial begin
    int burst;
    burst = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!stalls_on) begin
        out_ready_i = 1'b1;
        burst = 0;
      end else begin
        if (burst == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            out_ready_i = 1'b0;
            burst = $urandom_range(1, 18);
          end else begin
            out_ready_i = 1'b1;
            burst = $urandom_range(1, 24);
          end
        end
        burst--;
      end
    end
  end

  always @(posedge clk_i) begin
    qvr_out_t exp_rot;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rotations_due.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", out_data_o));
      end else begin
        exp_rot = rotations_due.pop_front();
        if (out_data_o.rot_x !== exp_rot.rot_x)
          note_mismatch($sformatf("rot_x got %0d want %0d",
                                  $signed(out_data_o.rot_x), $signed(exp_rot.rot_x)));
        if (out_data_o.rot_y !== exp_rot.rot_y)
          note_mismatch($sformatf("rot_y got %0d want %0d",
                                  $signed(out_data_o.rot_y), $signed(exp_rot.rot_y)));
        if (out_data_o.rot_z !== exp_rot.rot_z)
          note_mismatch($sformatf("rot_z got %0d want %0d",
                                  $signed(out_data_o.rot_z), $signed(exp_rot.rot_z)));
        if (out_data_o.clipped !== exp_rot.clipped)
          note_mismatch($sformatf("clipped got %b want %b",
                                  out_data_o.clipped, exp_rot.clipped));
      end
    end
  end

  task automatic test_basic_rotations();
    send_word(make_word(1, 2, 3, 16384, 0, 0, 0, 1'b0));
    send_word(make_word(0, 0, 0, 11585, 4000, -9000, 7000, 1'b1));
    // Quarter turn about z, forward and back.
    send_word(make_word(1000, 0, 0, 11585, 0, 0, 11585, 1'b0));
    send_word(make_word(1000, 0, 0, 11585, 0, 0, 11585, 1'b1));
    send_word(make_word(100, 200, 300, 0, 16384, 0, 0, 1'b0));
    send_word(make_word(-700, 1200, -5, 8192, 8192, 8192, 8192, 1'b1));
  endtask

  task automatic test_rounding_and_scale();
    // Quarter scale in each axis: halves round up on both signs.
    send_word(make_word(2, -2, 6, 8192, 0, 0, 0, 1'b0));
    send_word(make_word(1, -1, 3, 8192, 0, 0, 0, 1'b0));
    send_word(make_word(-3, 5, -7, 0, 0, 8192, 0, 1'b1));
  endtask

  task automatic test_saturation_extremes();
    send_word(make_word(32767, -32768, 32767, 16384, 0, 0, 0, 1'b0));
    send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
    send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
    send_word(make_word(-32768, 32767, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_word(make_word(-10000, 10000, 0, -32768, 0, 0, 0, 1'b0));
  endtask

  // The most negative vector part negated becomes +2.0 and must not wrap.
  task automatic test_negated_min_part();
    send_word(make_word(1, 1, 1, 0, -32768, 0, 0, 1'b1));
    send_word(make_word(-5, 9, 1, 3, 0, -32768, 0, 1'b1));
    send_word(make_word(7, -2, 4, 16384, 0, 0, -32768, 1'b1));
  endtask

  task automatic test_random_traffic(input int count);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (count) send_word(random_word());
  endtask

  task automatic test_pause_for_results();
    repeat (40) send_word(random_word());
    wait_for_results();
    repeat (40) send_word(random_word());
  endtask

  task automatic test_random_steady(input int count);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (count) send_word(random_word());
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_basic_rotations();
    test_rounding_and_scale();
    test_saturation_extremes();
    test_negated_min_part();
    test_random_traffic(1000);
    test_pause_for_results();
    test_random_steady(370);

    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
src/qvr_pkg.sv
src/qvr_round_sat.sv
src/quaternion_vector_rotate.sv
tb/sv/tb_top.sv
